### rtl/core/achf_pkg.sv
// shared types and constants for the active close handshake sequencer
`default_nettype none

package achf_pkg;

   // close phase, also the next action code for every phase but idle
   typedef enum logic [2:0] {
      PH_SEND_FIN  = 3'd0,
      PH_RECV_ACK  = 3'd1,
      PH_RECV_FIN  = 3'd2,
      PH_SEND_ACK  = 3'd3,
      PH_TIME_WAIT = 3'd4,
      PH_CLOSED    = 3'd5,
      PH_FAILED    = 3'd6,
      PH_IDLE      = 3'd7
   } phase_type;

   // dense error codes
   typedef enum logic [2:0] {
      ER_NONE    = 3'd0,
      ER_ACK_TMO = 3'd1,
      ER_FIN_TMO = 3'd2,
      ER_RST_ACK = 3'd3,
      ER_RST_FIN = 3'd4,
      ER_RST_TW  = 3'd5,
      ER_FATAL   = 3'd6,
      ER_SETUP   = 3'd7
   } err_type;

   // outcome codes of the requested action
   localparam logic [2:0] OC_OK    = 3'd0;
   localparam logic [2:0] OC_ERROR = 3'd1;
   localparam logic [2:0] OC_TMO   = 3'd2;
   localparam logic [2:0] OC_RST   = 3'd3;
   localparam logic [2:0] OC_FATAL = 3'd4;
   localparam logic [2:0] OC_SETUP = 3'd5;

   // item modes
   localparam logic MODE_START = 1'b0;

   // csr port
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIN_RETRIES = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WAIT_PERIOD = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RX_TIMEOUT  = 2'd2;

   // csr reset values
   localparam logic [7:0]  FIN_RETRIES_RST = 8'd3;
   localparam logic [31:0] WAIT_PERIOD_RST = 32'd1000000;
   localparam logic [31:0] RX_TIMEOUT_RST  = 32'd100000;

   typedef struct packed {
      logic [7:0]  fin_retries;
      logic [31:0] wait_period_us;
      logic [31:0] receive_timeout_us;
   } cfg_type;

   typedef struct packed {
      logic       mode;
      logic [2:0] outcome;
   } item_type;

   typedef struct packed {
      logic [2:0] next_action;
      logic [2:0] error_code;
   } result_type;

endpackage

`default_nettype wire

### rtl/core/achf_if.sv
// request and response channel interfaces
`default_nettype none

interface achf_req_if #(parameter int SEQ_BITS = 32);
   logic                valid;
   logic                ready;
   logic                mode;
   logic [2:0]          outcome;
   logic [SEQ_BITS-1:0] start_seq;

   modport source (output valid, mode, outcome, start_seq, input ready);
   modport sink   (input valid, mode, outcome, start_seq, output ready);
endinterface

interface achf_rsp_if #(parameter int SEQ_BITS = 32);
   logic                valid;
   logic                ready;
   logic [2:0]          next_action;
   logic [2:0]          error_code;
   logic [SEQ_BITS-1:0] seq_out;

   modport source (output valid, next_action, error_code, seq_out, input ready);
   modport sink   (input valid, next_action, error_code, seq_out, output ready);
endinterface

`default_nettype wire

### rtl/core/achf_fsm.sv
// close phase state machine with retry count, wait budget and sequence state
`default_nettype none

module achf_fsm #(
   parameter int SEQ_BITS = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire achf_pkg::item_type  item,
   input  wire logic [SEQ_BITS-1:0] start_seq,
   input  wire achf_pkg::cfg_type   cfg,
   output achf_pkg::result_type     result,
   output logic [SEQ_BITS-1:0]      seq_out
);

   achf_pkg::phase_type phase_ff, phase_in;
   achf_pkg::err_type   last_error_ff, last_error_in;
   logic [7:0]          retries_ff, retries_in;
   logic [31:0]         budget_ff, budget_in;
   logic [SEQ_BITS-1:0] saved_seq_ff, saved_seq_in;
   logic [SEQ_BITS-1:0] cur_seq_ff, cur_seq_in;
   logic                active;
   logic                budget_gt;
   logic [SEQ_BITS-1:0] seq_plus;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= achf_pkg::PH_IDLE;
         last_error_ff <= achf_pkg::ER_NONE;
         retries_ff    <= '0;
         budget_ff     <= '0;
         saved_seq_ff  <= '0;
         cur_seq_ff    <= '0;
      end else begin
         phase_ff      <= phase_in;
         last_error_ff <= last_error_in;
         retries_ff    <= retries_in;
         budget_ff     <= budget_in;
         saved_seq_ff  <= saved_seq_in;
         cur_seq_ff    <= cur_seq_in;
      end
   end

   assign active    = (phase_ff <= achf_pkg::PH_TIME_WAIT);
   assign budget_gt = (budget_ff > cfg.receive_timeout_us);
   assign seq_plus  = saved_seq_ff + SEQ_BITS'(1);

   // next state for one item
   always_comb begin
      phase_in      = phase_ff;
      last_error_in = last_error_ff;
      retries_in    = retries_ff;
      budget_in     = budget_ff;
      saved_seq_in  = saved_seq_ff;
      cur_seq_in    = cur_seq_ff;
      if (step) begin
         priority if (item.mode == achf_pkg::MODE_START) begin
            // start restarts the close in any phase
            saved_seq_in  = start_seq;
            cur_seq_in    = start_seq;
            retries_in    = cfg.fin_retries;
            budget_in     = cfg.wait_period_us;
            last_error_in = achf_pkg::ER_NONE;
            phase_in      = achf_pkg::PH_SEND_FIN;
         end else if (item.outcome == achf_pkg::OC_FATAL && active) begin
            last_error_in = achf_pkg::ER_FATAL;
            phase_in      = achf_pkg::PH_FAILED;
         end else begin
            unique case (phase_ff)
               achf_pkg::PH_SEND_FIN: begin
                  if (item.outcome == achf_pkg::OC_OK) begin
                     cur_seq_in = seq_plus;
                     phase_in   = achf_pkg::PH_RECV_ACK;
                  end else begin
                     cur_seq_in = saved_seq_ff;
                  end
               end
               achf_pkg::PH_RECV_ACK: begin
                  priority if (item.outcome == achf_pkg::OC_OK) begin
                     phase_in = achf_pkg::PH_RECV_FIN;
                  end else if (item.outcome == achf_pkg::OC_RST) begin
                     last_error_in = achf_pkg::ER_RST_ACK;
                     phase_in      = achf_pkg::PH_CLOSED;
                  end else if (retries_ff == '0) begin
                     last_error_in = achf_pkg::ER_ACK_TMO;
                     phase_in      = achf_pkg::PH_FAILED;
                  end else begin
                     // resend the FIN|ACK
                     retries_in = retries_ff - 8'd1;
                     cur_seq_in = saved_seq_ff;
                     phase_in   = achf_pkg::PH_SEND_FIN;
                  end
               end
               achf_pkg::PH_RECV_FIN: begin
                  priority if (item.outcome == achf_pkg::OC_OK) begin
                     phase_in = achf_pkg::PH_SEND_ACK;
                  end else if (item.outcome == achf_pkg::OC_RST) begin
                     last_error_in = achf_pkg::ER_RST_FIN;
                     phase_in      = achf_pkg::PH_CLOSED;
                  end else if (budget_ff != '0) begin
                     // saturating budget subtract
                     budget_in = budget_gt ? budget_ff - cfg.receive_timeout_us : '0;
                  end else begin
                     last_error_in = achf_pkg::ER_FIN_TMO;
                     phase_in      = achf_pkg::PH_CLOSED;
                  end
               end
               achf_pkg::PH_SEND_ACK: begin
                  if (item.outcome == achf_pkg::OC_OK) begin
                     phase_in = achf_pkg::PH_TIME_WAIT;
                  end
               end
               achf_pkg::PH_TIME_WAIT: begin
                  priority if (item.outcome == achf_pkg::OC_SETUP) begin
                     last_error_in = achf_pkg::ER_SETUP;
                     phase_in      = achf_pkg::PH_CLOSED;
                  end else if (item.outcome == achf_pkg::OC_OK) begin
                     phase_in = achf_pkg::PH_SEND_ACK;
                  end else if (item.outcome == achf_pkg::OC_RST) begin
                     last_error_in = achf_pkg::ER_RST_TW;
                     phase_in      = achf_pkg::PH_CLOSED;
                  end else if (item.outcome == achf_pkg::OC_ERROR ||
                               item.outcome == achf_pkg::OC_TMO ||
                               item.outcome > achf_pkg::OC_SETUP) begin
                     // receive failure in time-wait closes, error kept
                     phase_in = achf_pkg::PH_CLOSED;
                  end
               end
               achf_pkg::PH_CLOSED, achf_pkg::PH_FAILED, achf_pkg::PH_IDLE: begin
                  // reports are ignored here
               end
            endcase
         end
      end
   end

   // answer reflects the updated state
   always_comb begin
      if (phase_in == achf_pkg::PH_IDLE) begin
         result.next_action = 3'(achf_pkg::PH_CLOSED);
         result.error_code  = 3'(achf_pkg::ER_NONE);
      end else begin
         result.next_action = 3'(phase_in);
         result.error_code  = 3'(last_error_in);
      end
      seq_out = cur_seq_in;
   end

`ifndef NO_ASSERTIONS
   // an error is only ever held in a terminal phase
   a_err_terminal: assert property (@(posedge clock) disable iff (reset)
      last_error_ff != achf_pkg::ER_NONE |->
         phase_ff == achf_pkg::PH_CLOSED || phase_ff == achf_pkg::PH_FAILED)
      else $error("error code set outside closed or failed");

   // state moves only on a transfer
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(cur_seq_ff) && $stable(budget_ff))
      else $error("state changed without a transfer");

   // waiting for the ACK always uses the advanced sequence number
   a_seq_after_fin: assert property (@(posedge clock) disable iff (reset)
      phase_ff == achf_pkg::PH_RECV_ACK |-> cur_seq_ff == saved_seq_ff + SEQ_BITS'(1))
      else $error("sequence number not advanced after FIN sent");
`endif

endmodule

`default_nettype wire

### rtl/core/active_close_handshake_fsm.sv
// Active close sequencer top level: input stage, csr bank, phase machine, response stage.
// Path: a request is held in the input stage, then its answer in the response stage.
// Throughput: one request per cycle unless rsp_ch stalls; phase update is combinational.
// The input stage accepts while a finished response waits on rsp_ch, if it is empty.
// Reset: synchronous; clears both stage valids, sets phase to idle and csrs to defaults.
`default_nettype none

module active_close_handshake_fsm #(
   parameter int SEQ_BITS = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   achf_req_if.sink                                  req_ch,
   achf_rsp_if.source                                rsp_ch,
   input  wire logic                                 csr_we,
   input  wire logic [achf_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [achf_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   achf_pkg::cfg_type    cfg_ff, cfg_in;
   logic                 in_valid_ff, in_valid_in;
   achf_pkg::item_type   in_item_ff;
   logic [SEQ_BITS-1:0]  in_seq_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   achf_pkg::result_type rsp_res_ff;
   logic [SEQ_BITS-1:0]  rsp_seq_ff;
   achf_pkg::result_type fsm_res;
   logic [SEQ_BITS-1:0]  fsm_seq;
   logic                 advance;
   logic                 req_rdy;

   // csr writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            achf_pkg::CSR_FIN_RETRIES: cfg_in.fin_retries        = csr_wdata[7:0];
            achf_pkg::CSR_WAIT_PERIOD: cfg_in.wait_period_us     = csr_wdata[31:0];
            achf_pkg::CSR_RX_TIMEOUT:  cfg_in.receive_timeout_us = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // stage handshake
   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_rdy = !in_valid_ff || advance;
   assign req_ch.ready = req_rdy;

   always_comb begin
      in_valid_in  = req_rdy ? req_ch.valid : in_valid_ff;
      rsp_valid_in = (!rsp_valid_ff || rsp_ch.ready) ? in_valid_ff : rsp_valid_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fin_retries        <= achf_pkg::FIN_RETRIES_RST;
         cfg_ff.wait_period_us     <= achf_pkg::WAIT_PERIOD_RST;
         cfg_ff.receive_timeout_us <= achf_pkg::RX_TIMEOUT_RST;
         in_valid_ff               <= 1'b0;
         rsp_valid_ff              <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_rdy && req_ch.valid) begin
         in_item_ff.mode    <= req_ch.mode;
         in_item_ff.outcome <= req_ch.outcome;
         in_seq_ff          <= req_ch.start_seq;
      end
      if (advance) begin
         rsp_res_ff <= fsm_res;
         rsp_seq_ff <= fsm_seq;
      end
   end

   // phase machine
   achf_fsm #(
      .SEQ_BITS (SEQ_BITS)
   ) u_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (in_item_ff),
      .start_seq (in_seq_ff),
      .cfg       (cfg_ff),
      .result    (fsm_res),
      .seq_out   (fsm_seq)
   );

   // response channel
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.next_action = rsp_res_ff.next_action;
   assign rsp_ch.error_code  = rsp_res_ff.error_code;
   assign rsp_ch.seq_out     = rsp_seq_ff;

`ifndef NO_ASSERTIONS
   // no response shows right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid after reset");

   // a held input item is never dropped
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("input stage lost an item");

   // a waiting response keeps its payload until the transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |=>
         rsp_valid_ff && $stable(rsp_res_ff) && $stable(rsp_seq_ff))
      else $error("waiting response changed");
`endif

endmodule

`default_nettype wire

### tb/active_close_handshake_fsm_tb.sv
// testbench for the active close sequencer: close sequences, response prediction and checks

module active_close_handshake_fsm_tb;
   localparam int   SEQ_BITS     = 32;
   localparam logic MODE_REPORT  = ~achf_pkg::MODE_START;
   localparam int   HOLD_CYCLES  = 300;
   localparam int   STALL_LIMIT  = 2000;
   localparam int   DRAIN_CYCLES = 4;

   // predicts every response of the close sequencer and checks responses in order
   class close_sequence_board;
      typedef struct packed {
         logic [2:0]          next_action;
         logic [2:0]          error_code;
         logic [SEQ_BITS-1:0] seq_out;
      } answer_type;

      achf_pkg::cfg_type   cfg;
      achf_pkg::phase_type phase;
      logic [7:0]          retries_left;
      logic [31:0]         wait_budget;
      logic [SEQ_BITS-1:0] saved_seq;
      logic [SEQ_BITS-1:0] current_seq;
      achf_pkg::err_type   last_error;
      answer_type          pending_answers[$];
      int                  error_count;

      function new();
         cfg.fin_retries        = achf_pkg::FIN_RETRIES_RST;
         cfg.wait_period_us     = achf_pkg::WAIT_PERIOD_RST;
         cfg.receive_timeout_us = achf_pkg::RX_TIMEOUT_RST;
         phase        = achf_pkg::PH_IDLE;
         retries_left = '0;
         wait_budget  = '0;
         saved_seq    = '0;
         current_seq  = '0;
         last_error   = achf_pkg::ER_NONE;
         error_count  = 0;
      endfunction

      function void write_reg(logic [achf_pkg::CSR_IDX_BITS-1:0] index,
                              logic [achf_pkg::CSR_DATA_BITS-1:0] data);
         case (index)
            achf_pkg::CSR_FIN_RETRIES: cfg.fin_retries        = data[7:0];
            achf_pkg::CSR_WAIT_PERIOD: cfg.wait_period_us     = data;
            achf_pkg::CSR_RX_TIMEOUT:  cfg.receive_timeout_us = data;
            default: ;
         endcase
      endfunction

      function int outstanding();
         return pending_answers.size();
      endfunction

      // advance the close phase for one accepted request and queue the answer
      function void note_request(logic mode, logic [2:0] outcome,
                                 logic [SEQ_BITS-1:0] start_seq);
         logic       rx_fail;
         answer_type answer;
         rx_fail = (outcome == achf_pkg::OC_ERROR) || (outcome == achf_pkg::OC_TMO) ||
                   (outcome >= achf_pkg::OC_SETUP);
         if (mode == achf_pkg::MODE_START) begin
            saved_seq    = start_seq;
            current_seq  = start_seq;
            retries_left = cfg.fin_retries;
            wait_budget  = cfg.wait_period_us;
            last_error   = achf_pkg::ER_NONE;
            phase        = achf_pkg::PH_SEND_FIN;
         end else if (outcome == achf_pkg::OC_FATAL && phase <= achf_pkg::PH_TIME_WAIT) begin
            last_error = achf_pkg::ER_FATAL;
            phase      = achf_pkg::PH_FAILED;
         end else begin
            case (phase)
               achf_pkg::PH_SEND_FIN: begin
                  current_seq = saved_seq;
                  if (outcome == achf_pkg::OC_OK) begin
                     current_seq = saved_seq + 1'b1;
                     phase       = achf_pkg::PH_RECV_ACK;
                  end
               end
               achf_pkg::PH_RECV_ACK: begin
                  if (outcome == achf_pkg::OC_OK) begin
                     phase = achf_pkg::PH_RECV_FIN;
                  end else if (outcome == achf_pkg::OC_RST) begin
                     last_error = achf_pkg::ER_RST_ACK;
                     phase      = achf_pkg::PH_CLOSED;
                  end else if (retries_left == 8'd0) begin
                     last_error = achf_pkg::ER_ACK_TMO;
                     phase      = achf_pkg::PH_FAILED;
                  end else begin
                     retries_left = retries_left - 8'd1;
                     current_seq  = saved_seq;
                     phase        = achf_pkg::PH_SEND_FIN;
                  end
               end
               achf_pkg::PH_RECV_FIN: begin
                  if (outcome == achf_pkg::OC_OK) begin
                     phase = achf_pkg::PH_SEND_ACK;
                  end else if (outcome == achf_pkg::OC_RST) begin
                     last_error = achf_pkg::ER_RST_FIN;
                     phase      = achf_pkg::PH_CLOSED;
                  end else if (wait_budget != 32'd0) begin
                     // saturating budget subtract
                     wait_budget = (wait_budget > cfg.receive_timeout_us) ?
                                   wait_budget - cfg.receive_timeout_us : 32'd0;
                  end else begin
                     last_error = achf_pkg::ER_FIN_TMO;
                     phase      = achf_pkg::PH_CLOSED;
                  end
               end
               achf_pkg::PH_SEND_ACK: begin
                  if (outcome == achf_pkg::OC_OK) phase = achf_pkg::PH_TIME_WAIT;
               end
               achf_pkg::PH_TIME_WAIT: begin
                  if (outcome == achf_pkg::OC_SETUP) begin
                     last_error = achf_pkg::ER_SETUP;
                     phase      = achf_pkg::PH_CLOSED;
                  end else if (outcome == achf_pkg::OC_OK) begin
                     phase = achf_pkg::PH_SEND_ACK;
                  end else if (outcome == achf_pkg::OC_RST) begin
                     last_error = achf_pkg::ER_RST_TW;
                     phase      = achf_pkg::PH_CLOSED;
                  end else if (rx_fail) begin
                     phase = achf_pkg::PH_CLOSED;
                  end
               end
               default: ;
            endcase
         end
         answer.next_action = (phase == achf_pkg::PH_IDLE) ? achf_pkg::PH_CLOSED : phase;
         answer.error_code  = (phase == achf_pkg::PH_IDLE) ? achf_pkg::ER_NONE : last_error;
         answer.seq_out     = current_seq;
         pending_answers.push_back(answer);
      endfunction

      // compare one response transfer with the oldest queued answer
      function void check_response(logic [2:0] next_action, logic [2:0] error_code,
                                   logic [SEQ_BITS-1:0] seq_out);
         answer_type want;
         if (pending_answers.size() == 0) begin
            $error("response with no request pending: next_action %0d", next_action);
            error_count++;
            return;
         end
         want = pending_answers.pop_front();
         if (next_action !== want.next_action) begin
            $error("next_action: expected %0d, actual %0d", want.next_action, next_action);
            error_count++;
         end
         if (error_code !== want.error_code) begin
            $error("error_code: expected %0d, actual %0d", want.error_code, error_code);
            error_count++;
         end
         if (seq_out !== want.seq_out) begin
            $error("seq_out: expected 0x%h, actual 0x%h", want.seq_out, seq_out);
            error_count++;
         end
      endfunction
   endclass

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_we;
   logic [achf_pkg::CSR_IDX_BITS-1:0]  csr_index;
   logic [achf_pkg::CSR_DATA_BITS-1:0] csr_wdata;

   int req_idle_pct     = 0;
   int rsp_idle_pct     = 0;
   bit hold_off_request = 1'b0;
   int stall_cycles     = 0;

   achf_req_if #(.SEQ_BITS(SEQ_BITS)) req_ch ();
   achf_rsp_if #(.SEQ_BITS(SEQ_BITS)) rsp_ch ();

   close_sequence_board board;

   active_close_handshake_fsm #(
      .SEQ_BITS(SEQ_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // transfer monitor and stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            board.note_request(req_ch.mode, req_ch.outcome, req_ch.start_seq);
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_response(rsp_ch.next_action, rsp_ch.error_code, rsp_ch.seq_out);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // response side: random back-pressure, one long hold-off on request
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // offer one request and wait for its transfer
   task automatic send_request(logic mode, logic [2:0] outcome, logic [SEQ_BITS-1:0] start_seq);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.mode      <= mode;
      req_ch.outcome   <= outcome;
      req_ch.start_seq <= start_seq;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // stop offering and wait until every answer has come back
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [achf_pkg::CSR_IDX_BITS-1:0] index,
                            logic [achf_pkg::CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      board.write_reg(index, data);
      @(posedge clock);
   endtask

   task automatic program_settings(logic [7:0] fin_retries, logic [31:0] wait_period,
                                   logic [31:0] rx_timeout);
      write_csr(achf_pkg::CSR_FIN_RETRIES, {24'd0, fin_retries});
      write_csr(achf_pkg::CSR_WAIT_PERIOD, wait_period);
      write_csr(achf_pkg::CSR_RX_TIMEOUT, rx_timeout);
      csr_we <= 1'b0;
   endtask

   // outcome mix biased toward ok so that sequences reach the late phases
   function automatic logic [2:0] pick_outcome(int ok_pct);
      int pick;
      if ($urandom_range(0, 99) < ok_pct) return achf_pkg::OC_OK;
      pick = $urandom_range(0, 99);
      if (pick < 32) return achf_pkg::OC_ERROR;
      if (pick < 64) return achf_pkg::OC_TMO;
      if (pick < 80) return achf_pkg::OC_RST;
      if (pick < 86) return achf_pkg::OC_FATAL;
      return achf_pkg::OC_SETUP;
   endfunction

   function automatic logic [SEQ_BITS-1:0] pick_seq();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // start items each followed by a run of reports, with some lone reports as noise
   task automatic run_close_sequences(int count);
      int sent;
      int len;
      int ok_pct;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            send_request(MODE_REPORT, 3'($urandom_range(0, 5)), $urandom);
         end else begin
            ok_pct = $urandom_range(30, 90);
            len    = $urandom_range(1, 14);
            send_request(achf_pkg::MODE_START, 3'($urandom_range(0, 5)), pick_seq());
            sent++;
            repeat (len) begin
               send_request(MODE_REPORT, pick_outcome(ok_pct), $urandom);
               sent++;
            end
         end
      end
   endtask

   initial begin
      board = new();
      req_ch.valid     <= 1'b0;
      req_ch.mode      <= achf_pkg::MODE_START;
      req_ch.outcome   <= achf_pkg::OC_OK;
      req_ch.start_seq <= '0;
      csr_we           <= 1'b0;
      csr_index        <= achf_pkg::CSR_FIN_RETRIES;
      csr_wdata        <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct = 32;
      rsp_idle_pct = 48;

      // report while idle is ignored
      send_request(MODE_REPORT, achf_pkg::OC_RST, 32'h0BAD_F00D);
      // full close with sequence wrap, send errors and a repeated FIN|ACK in time-wait
      send_request(achf_pkg::MODE_START, achf_pkg::OC_OK, 32'hFFFF_FFFF);
      send_request(MODE_REPORT, achf_pkg::OC_TMO, 32'h0);
      send_request(MODE_REPORT, achf_pkg::OC_OK, 32'h0);
      send_request(MODE_REPORT, achf_pkg::OC_OK, 32'h0);
      send_request(MODE_REPORT, achf_pkg::OC_OK, 32'h0);
      send_request(MODE_REPORT, achf_pkg::OC_ERROR, 32'h0);
      send_request(MODE_REPORT, achf_pkg::OC_OK, 32'h0);
      send_request(MODE_REPORT, achf_pkg::OC_OK, 32'h0);
      send_request(MODE_REPORT, achf_pkg::OC_OK, 32'h0);
      send_request(MODE_REPORT, achf_pkg::OC_SETUP, 32'h0);
      // report after closed repeats the answer
      send_request(MODE_REPORT, achf_pkg::OC_OK, 32'hFFFF_FFFF);
      // fatal, then a report after failed
      send_request(achf_pkg::MODE_START, achf_pkg::OC_FATAL, 32'h0);
      send_request(MODE_REPORT, achf_pkg::OC_FATAL, 32'h0);
      send_request(MODE_REPORT, achf_pkg::OC_OK, 32'h0);
      // reset seen while waiting for the ACK
      send_request(achf_pkg::MODE_START, achf_pkg::OC_OK, 32'h1234_5678);
      send_request(MODE_REPORT, achf_pkg::OC_OK, 32'h0);
      send_request(MODE_REPORT, achf_pkg::OC_RST, 32'h0);
      // reset seen while waiting for the FIN|ACK, restart mid-close
      send_request(achf_pkg::MODE_START, achf_pkg::OC_OK, 32'hA5A5_A5A5);
      send_request(MODE_REPORT, achf_pkg::OC_OK, 32'h0);
      send_request(achf_pkg::MODE_START, achf_pkg::OC_OK, 32'h5A5A_5A5A);
      send_request(MODE_REPORT, achf_pkg::OC_OK, 32'h0);
      send_request(MODE_REPORT, achf_pkg::OC_OK, 32'h0);
      send_request(MODE_REPORT, achf_pkg::OC_RST, 32'h0);
      settle();

      // no retries and no wait budget: ack timeout, then fin timeout
      program_settings(8'd0, 32'd0, 32'd5);
      send_request(achf_pkg::MODE_START, achf_pkg::OC_OK, 32'h8000_0000);
      send_request(MODE_REPORT, achf_pkg::OC_OK, 32'h0);
      send_request(MODE_REPORT, achf_pkg::OC_ERROR, 32'h0);
      send_request(achf_pkg::MODE_START, achf_pkg::OC_OK, 32'h7FFF_FFFF);
      send_request(MODE_REPORT, achf_pkg::OC_OK, 32'h0);
      send_request(MODE_REPORT, achf_pkg::OC_OK, 32'h0);
      send_request(MODE_REPORT, achf_pkg::OC_TMO, 32'h0);
      settle();

      // small budget, a few receive failures exhaust it
      program_settings(8'd1, 32'd250, 32'd100);
      run_close_sequences(220);
      settle();

      req_idle_pct = 48;
      rsp_idle_pct = 32;
      // widest settings, with one long response hold-off
      program_settings(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_close_sequences(110);
      hold_off_request = 1'b1;
      run_close_sequences(110);
      settle();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      program_settings(achf_pkg::FIN_RETRIES_RST, achf_pkg::WAIT_PERIOD_RST,
                       achf_pkg::RX_TIMEOUT_RST);
      run_close_sequences(170);
      settle();

      // zero receive timeout keeps the budget where it is
      program_settings(8'($urandom_range(0, 4)), $urandom, 32'd0);
      run_close_sequences(170);
      settle();

      if (board.error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

### filelist.f
rtl/core/achf_pkg.sv
rtl/core/achf_if.sv
rtl/core/achf_fsm.sv
rtl/core/active_close_handshake_fsm.sv
tb/active_close_handshake_fsm_tb.sv
